>>> sv/obc_pkg.sv
// ----------------------------------------------------------------------------
// obc_pkg
// shared types, register codes and helpers for the oriented box collision check
// ----------------------------------------------------------------------------
package obc_pkg;

    // command codes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HALF_LENGTH = 2'd0,
        CFG_HALF_WIDTH  = 2'd1,
        CFG_OFFSET_X    = 2'd2,
        CFG_COUNT       = 2'd3
    } cfg_idx_t;

    localparam logic [14:0] RESET_HALF_LENGTH = 15'd639;
    localparam logic [14:0] RESET_HALF_WIDTH  = 15'd237;
    localparam logic [15:0] RESET_OFFSET_X    = 16'd357;

    typedef logic signed [15:0] coord_t;   // Q7.8 coordinate or Q1.14 trig
    typedef logic [14:0]        extent_t;  // Q7.8 half size
    typedef logic signed [16:0] vcoord_t;  // vehicle x after offset
    typedef logic signed [17:0] diff_t;    // centre difference
    typedef logic signed [30:0] prod_t;    // trig * extent
    typedef logic [30:0]        prodm_t;
    typedef logic [31:0]        extsum_t;  // |a| + |b|
    typedef logic signed [33:0] bound_t;   // box bound at scale 2^22
    typedef logic signed [33:0] lhsp_t;    // diff * trig
    typedef logic signed [34:0] lhss_t;
    typedef logic [34:0]        lhsm_t;
    typedef logic signed [46:0] rhsp_t;    // (trig * extent) * trig
    typedef logic signed [47:0] rhss_t;
    typedef logic [47:0]        rhsm_t;
    typedef logic [49:0]        cmp_t;     // compare width at scale 2^36

    // one stored obstacle
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic [14:0]        hl;
        logic [14:0]        hw;
    } entry_t;

    // vehicle terms held for the whole scan
    typedef struct packed {
        logic signed [16:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic [14:0]        hl;
        logic [14:0]        hw;
        logic signed [30:0] qa;   // c * hl
        logic signed [30:0] qb;   // s * hw
        logic signed [30:0] qc;   // s * hl
        logic signed [30:0] qd;   // c * hw
        logic signed [33:0] lox;
        logic signed [33:0] hix;
        logic signed [33:0] loy;
        logic signed [33:0] hiy;
    } veh_t;

    // pipeline status towards the sequencer
    typedef struct packed {
        logic active;
        logic hit_valid;
        logic hit;
    } pipe_status_t;

    function automatic prodm_t abs_prod(input prod_t v);
        prod_t n;
        n = -v;
        abs_prod = v[30] ? prodm_t'(n) : prodm_t'(v);
    endfunction

    function automatic extsum_t ext_sum(input prod_t a, input prod_t b);
        ext_sum = extsum_t'(abs_prod(a)) + extsum_t'(abs_prod(b));
    endfunction

endpackage

>>> sv/obc_store.sv
// ----------------------------------------------------------------------------
// obc_store
// obstacle table, one write and one registered read port
// ----------------------------------------------------------------------------
module obc_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  obc_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output obc_pkg::entry_t rd_data
);

    obc_pkg::entry_t mem [DEPTH];
    obc_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/obc_sat_pipe.sv
// ----------------------------------------------------------------------------
// obc_sat_pipe
// per-obstacle box reject and separating-axis test, one obstacle a cycle
// ----------------------------------------------------------------------------
module obc_sat_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  issue,
    input  obc_pkg::entry_t       rd_data,
    input  obc_pkg::veh_t         veh,
    output obc_pkg::pipe_status_t status
);

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1
    obc_pkg::prod_t   pa_reg, pb_reg, pc_reg, pd_reg;
    obc_pkg::diff_t   sx_reg, sy_reg;
    obc_pkg::coord_t  oc1_reg, os1_reg, ocx1_reg, ocy1_reg;
    obc_pkg::extent_t ohl1_reg, ohw1_reg;
    // stage 2
    obc_pkg::extsum_t oex_reg, oey_reg;
    obc_pkg::lhsp_t   lp_reg [8];
    obc_pkg::rhsp_t   rp_reg [16];
    obc_pkg::coord_t  ocx2_reg, ocy2_reg;
    obc_pkg::extent_t ohl2_reg, ohw2_reg;
    // stage 3
    obc_pkg::lhss_t   ls_reg [4];
    obc_pkg::rhss_t   ra_reg [4];
    obc_pkg::rhss_t   rb_reg [4];
    obc_pkg::bound_t  olox_reg, ohix_reg, oloy_reg, ohiy_reg;
    obc_pkg::extent_t ohl3_reg, ohw3_reg;
    // stage 4
    logic             aabb_reg;
    obc_pkg::lhsm_t   lm_reg [4];
    obc_pkg::rhsm_t   am_reg [4];
    obc_pkg::rhsm_t   bm_reg [4];
    obc_pkg::extent_t ohl4_reg, ohw4_reg;
    // stage 5
    logic             hit_reg;

    obc_pkg::bound_t  ocx_sc, ocy_sc;
    obc_pkg::extent_t axis_ext [4];
    logic [3:0]       sep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: obstacle half-axis vectors and centre difference
    always_ff @(posedge clk)
    begin
        pa_reg   <= obc_pkg::prod_t'(rd_data.c) * obc_pkg::prod_t'({1'b0, rd_data.hl});
        pb_reg   <= obc_pkg::prod_t'(rd_data.s) * obc_pkg::prod_t'({1'b0, rd_data.hw});
        pc_reg   <= obc_pkg::prod_t'(rd_data.s) * obc_pkg::prod_t'({1'b0, rd_data.hl});
        pd_reg   <= obc_pkg::prod_t'(rd_data.c) * obc_pkg::prod_t'({1'b0, rd_data.hw});
        sx_reg   <= obc_pkg::diff_t'(rd_data.cx) - obc_pkg::diff_t'(veh.cx);
        sy_reg   <= obc_pkg::diff_t'(rd_data.cy) - obc_pkg::diff_t'(veh.cy);
        oc1_reg  <= rd_data.c;
        os1_reg  <= rd_data.s;
        ocx1_reg <= rd_data.cx;
        ocy1_reg <= rd_data.cy;
        ohl1_reg <= rd_data.hl;
        ohw1_reg <= rd_data.hw;
    end

    // stage 2: obstacle extents and the projection products
    always_ff @(posedge clk)
    begin
        oex_reg <= obc_pkg::ext_sum(pa_reg, pb_reg);
        oey_reg <= obc_pkg::ext_sum(pc_reg, pd_reg);

        lp_reg[0] <= obc_pkg::lhsp_t'(sx_reg) * obc_pkg::lhsp_t'(veh.c);
        lp_reg[1] <= obc_pkg::lhsp_t'(sy_reg) * obc_pkg::lhsp_t'(veh.s);
        lp_reg[2] <= obc_pkg::lhsp_t'(sx_reg) * obc_pkg::lhsp_t'(veh.s);
        lp_reg[3] <= obc_pkg::lhsp_t'(sy_reg) * obc_pkg::lhsp_t'(veh.c);
        lp_reg[4] <= obc_pkg::lhsp_t'(sx_reg) * obc_pkg::lhsp_t'(oc1_reg);
        lp_reg[5] <= obc_pkg::lhsp_t'(sy_reg) * obc_pkg::lhsp_t'(os1_reg);
        lp_reg[6] <= obc_pkg::lhsp_t'(sx_reg) * obc_pkg::lhsp_t'(os1_reg);
        lp_reg[7] <= obc_pkg::lhsp_t'(sy_reg) * obc_pkg::lhsp_t'(oc1_reg);

        // obstacle sides on the vehicle axes
        rp_reg[0]  <= obc_pkg::rhsp_t'(pa_reg) * obc_pkg::rhsp_t'(veh.c);
        rp_reg[1]  <= obc_pkg::rhsp_t'(pc_reg) * obc_pkg::rhsp_t'(veh.s);
        rp_reg[2]  <= obc_pkg::rhsp_t'(pb_reg) * obc_pkg::rhsp_t'(veh.c);
        rp_reg[3]  <= obc_pkg::rhsp_t'(pd_reg) * obc_pkg::rhsp_t'(veh.s);
        rp_reg[4]  <= obc_pkg::rhsp_t'(pa_reg) * obc_pkg::rhsp_t'(veh.s);
        rp_reg[5]  <= obc_pkg::rhsp_t'(pc_reg) * obc_pkg::rhsp_t'(veh.c);
        rp_reg[6]  <= obc_pkg::rhsp_t'(pb_reg) * obc_pkg::rhsp_t'(veh.s);
        rp_reg[7]  <= obc_pkg::rhsp_t'(pd_reg) * obc_pkg::rhsp_t'(veh.c);
        // vehicle sides on the obstacle axes
        rp_reg[8]  <= obc_pkg::rhsp_t'(veh.qa) * obc_pkg::rhsp_t'(oc1_reg);
        rp_reg[9]  <= obc_pkg::rhsp_t'(veh.qc) * obc_pkg::rhsp_t'(os1_reg);
        rp_reg[10] <= obc_pkg::rhsp_t'(veh.qb) * obc_pkg::rhsp_t'(oc1_reg);
        rp_reg[11] <= obc_pkg::rhsp_t'(veh.qd) * obc_pkg::rhsp_t'(os1_reg);
        rp_reg[12] <= obc_pkg::rhsp_t'(veh.qa) * obc_pkg::rhsp_t'(os1_reg);
        rp_reg[13] <= obc_pkg::rhsp_t'(veh.qc) * obc_pkg::rhsp_t'(oc1_reg);
        rp_reg[14] <= obc_pkg::rhsp_t'(veh.qb) * obc_pkg::rhsp_t'(os1_reg);
        rp_reg[15] <= obc_pkg::rhsp_t'(veh.qd) * obc_pkg::rhsp_t'(oc1_reg);

        ocx2_reg <= ocx1_reg;
        ocy2_reg <= ocy1_reg;
        ohl2_reg <= ohl1_reg;
        ohw2_reg <= ohw1_reg;
    end

    assign ocx_sc = obc_pkg::bound_t'(ocx2_reg) <<< 14;
    assign ocy_sc = obc_pkg::bound_t'(ocy2_reg) <<< 14;

    // stage 3: projection sums and obstacle bounds
    always_ff @(posedge clk)
    begin
        ls_reg[0] <= obc_pkg::lhss_t'(lp_reg[0]) + obc_pkg::lhss_t'(lp_reg[1]);
        ls_reg[1] <= obc_pkg::lhss_t'(lp_reg[2]) - obc_pkg::lhss_t'(lp_reg[3]);
        ls_reg[2] <= obc_pkg::lhss_t'(lp_reg[4]) + obc_pkg::lhss_t'(lp_reg[5]);
        ls_reg[3] <= obc_pkg::lhss_t'(lp_reg[6]) - obc_pkg::lhss_t'(lp_reg[7]);

        ra_reg[0] <= obc_pkg::rhss_t'(rp_reg[0])  + obc_pkg::rhss_t'(rp_reg[1]);
        rb_reg[0] <= obc_pkg::rhss_t'(rp_reg[2])  - obc_pkg::rhss_t'(rp_reg[3]);
        ra_reg[1] <= obc_pkg::rhss_t'(rp_reg[4])  - obc_pkg::rhss_t'(rp_reg[5]);
        rb_reg[1] <= obc_pkg::rhss_t'(rp_reg[6])  + obc_pkg::rhss_t'(rp_reg[7]);
        ra_reg[2] <= obc_pkg::rhss_t'(rp_reg[8])  + obc_pkg::rhss_t'(rp_reg[9]);
        rb_reg[2] <= obc_pkg::rhss_t'(rp_reg[10]) - obc_pkg::rhss_t'(rp_reg[11]);
        ra_reg[3] <= obc_pkg::rhss_t'(rp_reg[12]) - obc_pkg::rhss_t'(rp_reg[13]);
        rb_reg[3] <= obc_pkg::rhss_t'(rp_reg[14]) + obc_pkg::rhss_t'(rp_reg[15]);

        olox_reg <= ocx_sc - obc_pkg::bound_t'(oex_reg);
        ohix_reg <= ocx_sc + obc_pkg::bound_t'(oex_reg);
        oloy_reg <= ocy_sc - obc_pkg::bound_t'(oey_reg);
        ohiy_reg <= ocy_sc + obc_pkg::bound_t'(oey_reg);
        ohl3_reg <= ohl2_reg;
        ohw3_reg <= ohw2_reg;
    end

    // stage 4: box reject and magnitudes
    always_ff @(posedge clk)
    begin
        aabb_reg <= !((veh.hix < olox_reg) || (veh.lox > ohix_reg) ||
                      (veh.hiy < oloy_reg) || (veh.loy > ohiy_reg));
        for (int k = 0; k < 4; k++)
        begin
            lm_reg[k] <= ls_reg[k][34] ? obc_pkg::lhsm_t'(-ls_reg[k])
                                       : obc_pkg::lhsm_t'(ls_reg[k]);
            am_reg[k] <= ra_reg[k][47] ? obc_pkg::rhsm_t'(-ra_reg[k])
                                       : obc_pkg::rhsm_t'(ra_reg[k]);
            bm_reg[k] <= rb_reg[k][47] ? obc_pkg::rhsm_t'(-rb_reg[k])
                                       : obc_pkg::rhsm_t'(rb_reg[k]);
        end
        ohl4_reg <= ohl3_reg;
        ohw4_reg <= ohw3_reg;
    end

    assign axis_ext[0] = veh.hl;
    assign axis_ext[1] = veh.hw;
    assign axis_ext[2] = ohl4_reg;
    assign axis_ext[3] = ohw4_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sep[k] = (obc_pkg::cmp_t'(lm_reg[k]) << 14) >
                     (obc_pkg::cmp_t'(am_reg[k]) + obc_pkg::cmp_t'(bm_reg[k]) +
                      (obc_pkg::cmp_t'(axis_ext[k]) << 28));
        end
    end

    // stage 5: overlap verdict
    always_ff @(posedge clk)
    begin
        hit_reg <= aabb_reg && (sep == 4'b0000);
    end

    assign status.active    = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign status.hit_valid = v5_reg;
    assign status.hit       = hit_reg;

endmodule

>>> sv/oriented_box_collision_check.sv
// ----------------------------------------------------------------------------
// oriented_box_collision_check
// table of oriented obstacle boxes tested against a vehicle box
// ----------------------------------------------------------------------------
// a write word is stored at its accept edge, gives no result and busy stays low
// a check word runs the vehicle set-up, then scans its n obstacles through the pipe
// and pulses done once the pipe has drained; busy falls at the edge where done rises
// the table read port walks one obstacle a cycle, and the next word is taken
// only once busy is low again after a check; the receiver cannot stall
// reset clears control and loads the register defaults; table contents stay
// undefined until written
module oriented_box_collision_check #(
    parameter int MAX_OBSTACLES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // command side
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [3:0]         entry_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] heading_cos,
    input  logic signed [15:0] heading_sin,
    input  logic [14:0]        half_length,
    input  logic [14:0]        half_width,
    // result side
    output logic               done,
    output logic               pose_free,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // table address and scan counter widths
    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CW = $clog2(MAX_OBSTACLES + 1);
    localparam logic [8:0] MAX_W = 9'(MAX_OBSTACLES);

    // one-hot sequencer
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PROD  = 6'b000010,   // vehicle half-axis products
        ST_EXT   = 6'b000100,   // vehicle extents
        ST_BOUND = 6'b001000,   // vehicle bounding box
        ST_SCAN  = 6'b010000,   // issue one table read a cycle
        ST_DRAIN = 6'b100000    // wait for the pipe to empty
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    obc_pkg::extent_t half_length_reg, half_width_reg;
    obc_pkg::coord_t  offset_x_reg;
    logic [4:0]       count_reg;

    // scan control
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] num_reg, num_next;
    logic          hit_reg, hit_next;
    logic          done_reg, done_next;
    logic          pose_free_reg;

    // vehicle terms
    obc_pkg::veh_t    veh_reg;
    obc_pkg::extsum_t vex_reg, vey_reg;
    obc_pkg::bound_t  vcx_sc, vcy_sc;

    logic            accept, check_go, wr_en, rd_en;
    obc_pkg::entry_t wr_data, rd_data;
    obc_pkg::pipe_status_t pipe_status;

    assign accept   = start && !busy;
    assign check_go = accept && (operation == obc_pkg::OP_CHECK);
    // slots outside the table are dropped
    assign wr_en    = accept && (operation == obc_pkg::OP_WRITE) &&
                      ({5'b00000, entry_index} < MAX_W);

    assign wr_data.cx = pos_x;
    assign wr_data.cy = pos_y;
    assign wr_data.c  = heading_cos;
    assign wr_data.s  = heading_sin;
    assign wr_data.hl = half_length;
    assign wr_data.hw = half_width;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= obc_pkg::RESET_HALF_LENGTH;
            half_width_reg  <= obc_pkg::RESET_HALF_WIDTH;
            offset_x_reg    <= obc_pkg::RESET_OFFSET_X;
            count_reg       <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (obc_pkg::cfg_idx_t'(cfg_index))
                obc_pkg::CFG_HALF_LENGTH: half_length_reg <= cfg_data[14:0];
                obc_pkg::CFG_HALF_WIDTH:  half_width_reg  <= cfg_data[14:0];
                obc_pkg::CFG_OFFSET_X:    offset_x_reg    <= cfg_data;
                obc_pkg::CFG_COUNT:       count_reg       <= cfg_data[4:0];
                default:                  ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        num_next   = num_reg;
        hit_next   = hit_reg | (pipe_status.hit_valid & pipe_status.hit);
        done_next  = 1'b0;
        rd_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (check_go)
                begin
                    state_next = ST_PROD;
                    hit_next   = 1'b0;
                    // clamp the count to the table depth
                    if ({4'b0000, count_reg} >= MAX_W)
                    begin
                        num_next = CW'(MAX_OBSTACLES);
                    end
                    else
                    begin
                        num_next = CW'(count_reg);
                    end
                end
            end
            ST_PROD:  state_next = ST_EXT;
            ST_EXT:   state_next = ST_BOUND;
            ST_BOUND:
            begin
                state_next = ST_SCAN;
                idx_next   = '0;
            end
            ST_SCAN:
            begin
                if (idx_reg < num_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // the last verdict was folded into hit_reg at the previous edge
                if (!pipe_status.active)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            num_reg   <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            num_reg   <= num_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            pose_free_reg <= !hit_reg;
        end
    end

    assign vcx_sc = obc_pkg::bound_t'(veh_reg.cx) <<< 14;
    assign vcy_sc = obc_pkg::bound_t'(veh_reg.cy) <<< 14;

    // vehicle box set-up through the PROD, EXT and BOUND states
    always_ff @(posedge clk)
    begin
        if (check_go)
        begin
            // box centre sits off the pose along x by the configured offset
            veh_reg.cx <= obc_pkg::vcoord_t'(pos_x) + obc_pkg::vcoord_t'(offset_x_reg);
            veh_reg.cy <= pos_y;
            veh_reg.c  <= heading_cos;
            veh_reg.s  <= heading_sin;
            veh_reg.hl <= half_length_reg;
            veh_reg.hw <= half_width_reg;
        end
        if (state_reg == ST_PROD)
        begin
            veh_reg.qa <= obc_pkg::prod_t'(veh_reg.c) * obc_pkg::prod_t'({1'b0, veh_reg.hl});
            veh_reg.qb <= obc_pkg::prod_t'(veh_reg.s) * obc_pkg::prod_t'({1'b0, veh_reg.hw});
            veh_reg.qc <= obc_pkg::prod_t'(veh_reg.s) * obc_pkg::prod_t'({1'b0, veh_reg.hl});
            veh_reg.qd <= obc_pkg::prod_t'(veh_reg.c) * obc_pkg::prod_t'({1'b0, veh_reg.hw});
        end
        if (state_reg == ST_EXT)
        begin
            vex_reg <= obc_pkg::ext_sum(veh_reg.qa, veh_reg.qb);
            vey_reg <= obc_pkg::ext_sum(veh_reg.qc, veh_reg.qd);
        end
        if (state_reg == ST_BOUND)
        begin
            veh_reg.lox <= vcx_sc - obc_pkg::bound_t'(vex_reg);
            veh_reg.hix <= vcx_sc + obc_pkg::bound_t'(vex_reg);
            veh_reg.loy <= vcy_sc - obc_pkg::bound_t'(vey_reg);
            veh_reg.hiy <= vcy_sc + obc_pkg::bound_t'(vey_reg);
        end
    end

    obc_store #(
        .DEPTH (MAX_OBSTACLES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    obc_sat_pipe u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (rd_en),
        .rd_data (rd_data),
        .veh     (veh_reg),
        .status  (pipe_status)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign pose_free = pose_free_reg;

endmodule
